>>> rtl/fct_pkg.sv
package fct_pkg;

  localparam int COORD_W = 32;
  localparam int CORNER_W = COORD_W + 1;
  localparam int PROD_W = COORD_W + CORNER_W;
  localparam int SUM_W = PROD_W + 3;

  localparam logic [2:0] CMD_WRITE  = 3'd0;
  localparam logic [2:0] CMD_POINT  = 3'd1;
  localparam logic [2:0] CMD_SPHERE = 3'd2;
  localparam logic [2:0] CMD_BOX    = 3'd3;
  localparam logic [2:0] CMD_CUBE   = 3'd4;

  typedef struct packed {
    logic        is_box;
    logic        is_sphere;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic signed [COORD_W-1:0] cz;
    logic signed [COORD_W-1:0] sx;
    logic signed [COORD_W-1:0] sy;
    logic signed [COORD_W-1:0] sz;
  } query_t;

endpackage

>>> rtl/fct_front.sv
module fct_front import fct_pkg::*; #(
  parameter int NUM_PLANES = 6
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [2:0]   cmd,
  input  logic [2:0]   plane_index,
  input  logic [1:0]   component_index,
  input  logic [31:0]  coef_value,
  input  query_t       q_in,
  output logic         wr_en,
  output logic [$clog2(NUM_PLANES*4)-1:0] wr_addr,
  output logic [31:0]  wr_data,
  output logic         q_valid,
  input  logic         q_ready,
  output query_t       q_out
);

  localparam int DEPTH = 2;

  query_t    fifo [DEPTH];
  logic      wptr, rptr;
  logic [1:0] count;
  logic      push, pop, is_query;

  assign is_query = (cmd == CMD_POINT) || (cmd == CMD_SPHERE) ||
                    (cmd == CMD_BOX) || (cmd == CMD_CUBE);
  // queries need a free slot; writes wait until no query is queued or running
  // (back end idle) so earlier queries see the old planes; dropped codes pass
  assign in_ready = is_query ? (count != 2'(DEPTH))
                             : ((cmd != CMD_WRITE) || (count == 2'd0 && q_ready));
  assign push = in_valid && in_ready && is_query;
  assign pop  = q_valid && q_ready;
  assign q_valid = count != 2'd0;
  assign q_out = fifo[rptr];

  assign wr_en = in_valid && in_ready && (cmd == CMD_WRITE) &&
                 (32'(plane_index) < 32'(NUM_PLANES));
  assign wr_addr = $bits(wr_addr)'({plane_index, component_index});
  assign wr_data = coef_value;

  always_ff @(posedge clk) begin
    if (push) fifo[wptr] <= q_in;
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= 2'(DEPTH))
    else $error("queue overflow");
  assert property (@(posedge clk) disable iff (rst)
    (count == 2'(DEPTH) && !pop) |=> count == 2'(DEPTH))
    else $error("full queue lost entry");
  assert property (@(posedge clk) disable iff (rst) wr_en |-> !push)
    else $error("write and query at once");

endmodule

>>> rtl/fct_back.sv
module fct_back import fct_pkg::*; #(
  parameter int NUM_PLANES = 6,
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [$clog2(NUM_PLANES*4)-1:0] wr_addr,
  input  logic [31:0] wr_data,
  input  logic        q_valid,
  output logic        q_ready,
  input  query_t      q_in,
  output logic        res_valid,
  input  logic        res_ready,
  output logic        res_visible
);

  localparam int PW = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;
  localparam logic [1:0] ST_IDLE = 2'd0, ST_RUN = 2'd1, ST_DONE = 2'd2;

  logic [31:0] store [NUM_PLANES*4];
  logic [1:0]  state;
  logic [PW-1:0] plane;
  query_t      q;
  logic        vis;
  logic signed [31:0] ca, cb, cc, cd;
  logic signed [CORNER_W-1:0] xs, ys, zs;
  logic signed [SUM_W-1:0] s, base;
  logic        pass;

  always_comb begin
    ca = store[{plane, 2'd0}];
    cb = store[{plane, 2'd1}];
    cc = store[{plane, 2'd2}];
    cd = store[{plane, 2'd3}];
    // pick the corner farthest along the plane normal
    if (q.is_box) begin
      xs = (ca[31] ^ q.sx[31]) ? CORNER_W'(q.cx) - CORNER_W'(q.sx)
                               : CORNER_W'(q.cx) + CORNER_W'(q.sx);
      ys = (cb[31] ^ q.sy[31]) ? CORNER_W'(q.cy) - CORNER_W'(q.sy)
                               : CORNER_W'(q.cy) + CORNER_W'(q.sy);
      zs = (cc[31] ^ q.sz[31]) ? CORNER_W'(q.cz) - CORNER_W'(q.sz)
                               : CORNER_W'(q.cz) + CORNER_W'(q.sz);
    end else begin
      xs = CORNER_W'(q.cx);
      ys = CORNER_W'(q.cy);
      zs = CORNER_W'(q.cz);
    end
    base = (SUM_W'(cd) + (q.is_sphere ? SUM_W'(q.sx) : SUM_W'(0))) <<< FRAC_BITS;
    s = SUM_W'(ca * xs) + SUM_W'(cb * ys) + SUM_W'(cc * zs) + base;
    pass = !s[SUM_W-1];
  end

  assign q_ready = state == ST_IDLE;
  assign res_valid = state == ST_DONE;
  assign res_visible = vis;

  always_ff @(posedge clk) begin
    if (q_valid && q_ready) q <= q_in;
    if (rst) begin
      state <= ST_IDLE;
      plane <= '0;
      vis <= 1'b1;
      for (int i = 0; i < NUM_PLANES*4; i++) store[i] <= '0;
    end else begin
      if (wr_en) store[wr_addr] <= wr_data;
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            state <= ST_RUN;
            plane <= '0;
            vis <= 1'b1;
          end
        end
        ST_RUN: begin
          vis <= vis & pass;
          if (32'(plane) == NUM_PLANES - 1) state <= ST_DONE;
          else plane <= plane + 1'b1;
        end
        ST_DONE: if (res_ready) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) res_valid && !res_ready |=> res_valid)
    else $error("result dropped");
  assert property (@(posedge clk) disable iff (rst) state == ST_RUN |-> 32'(plane) < NUM_PLANES)
    else $error("plane out of range");
  assert property (@(posedge clk) disable iff (rst)
    $past(state) == ST_IDLE && state == ST_RUN |-> vis)
    else $error("vis not primed");

endmodule

>>> rtl/frustum_cull_test_unit.sv
// Frustum cull test unit.
// Input stream s_axis: one command per transfer. Writes store a plane
// coefficient and give no result; point/sphere/box/cube queries give one
// m_axis transfer with visible in tdata bit 0. Unused command codes and
// writes to planes beyond NUM_PLANES are dropped.
// A query occupies the back end from its load, one plane per cycle
// through one shared multiply-accumulate, to its result state; the back end
// takes the next query only after that result has been transferred.
// For boxes the farthest corner along each normal is tested directly.
// A two-entry queue between decode and evaluation lets new queries be taken
// while a query runs or its result waits. A write waits until no query is
// queued or running, so every query sees the planes written before it.
// Reset clears the plane store (all tests pass) and empties the queue.
// When m_axis is stalled the result holds, the queue fills, and s_axis
// then deasserts tready for queries and writes.
module frustum_cull_test_unit import fct_pkg::*; #(
  parameter int NUM_PLANES = 6,
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // cmd[2:0], plane_index[5:3], component_index[7:6], coef_value[39:8],
  // center_x/y/z [71:40],[103:72],[135:104], size_x/y/z [167:136],[199:168],[231:200]
  input  logic [231:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // visible[0], zero fill above
  output logic [7:0]   m_axis_tdata
);

  query_t q_in, q_mid;
  logic wr_en, q_valid, q_ready, vis;
  logic [$clog2(NUM_PLANES*4)-1:0] wr_addr;
  logic [31:0] wr_data;

  assign q_in.is_box    = (s_axis_tdata[2:0] == CMD_BOX) || (s_axis_tdata[2:0] == CMD_CUBE);
  assign q_in.is_sphere = s_axis_tdata[2:0] == CMD_SPHERE;
  assign q_in.cx = s_axis_tdata[71:40];
  assign q_in.cy = s_axis_tdata[103:72];
  assign q_in.cz = s_axis_tdata[135:104];
  assign q_in.sx = s_axis_tdata[167:136];
  assign q_in.sy = (s_axis_tdata[2:0] == CMD_CUBE) ? s_axis_tdata[167:136]
                                                   : s_axis_tdata[199:168];
  assign q_in.sz = (s_axis_tdata[2:0] == CMD_CUBE) ? s_axis_tdata[167:136]
                                                   : s_axis_tdata[231:200];

  fct_front #(.NUM_PLANES(NUM_PLANES)) u_front (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .cmd(s_axis_tdata[2:0]), .plane_index(s_axis_tdata[5:3]),
    .component_index(s_axis_tdata[7:6]), .coef_value(s_axis_tdata[39:8]),
    .q_in, .wr_en, .wr_addr, .wr_data,
    .q_valid, .q_ready, .q_out(q_mid)
  );

  fct_back #(.NUM_PLANES(NUM_PLANES), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk, .rst, .wr_en, .wr_addr, .wr_data,
    .q_valid, .q_ready, .q_in(q_mid),
    .res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res_visible(vis)
  );

  assign m_axis_tdata = {7'd0, vis};

endmodule

>>> bench/frustum_cull_test_unit_tb.sv
`timescale 1ns / 1ps

module frustum_cull_test_unit_tb;
  import fct_pkg::*;

  localparam int N_PLANES = 6;
  localparam int FRAC_W = 16;
  localparam int N_RANDOM = 500;
  localparam int STALL_LIMIT = 5000;
  localparam int NO_CHECK = -1;

  typedef struct {
    logic [2:0]  cmd;
    logic [2:0]  plane;
    logic [1:0]  comp;
    logic [31:0] coef;
    logic [31:0] cx, cy, cz, sx, sy, sz;
    int          vis;   // typed-in visibility, or NO_CHECK to use the model
  } cull_req_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [231:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [7:0]   m_axis_tdata;

  logic signed [31:0] plane_coef [N_PLANES][4];
  bit   visible_q [$];
  int   errors = 0;
  int   idle_cycles = 0;
  int   burst_left = 0;
  int   ready_cycle = 0;
  int   ready_mode = 0;
  cull_req_t dir_rows [$];

  frustum_cull_test_unit DUT (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always #4 clk = ~clk;

  // a*x + b*y + c*z + (d + margin) * 2^FRAC_W >= 0, exact at 128 bits
  function automatic bit plane_passes(int p, logic signed [127:0] x, y, z, margin);
    logic signed [127:0] a, b, c, d, acc;
    a = plane_coef[p][0];
    b = plane_coef[p][1];
    c = plane_coef[p][2];
    d = plane_coef[p][3];
    acc = a * x + b * y + c * z + (d <<< FRAC_W) + (margin <<< FRAC_W);
    return acc >= 0;
  endfunction

  function automatic bit box_passes(int p, logic signed [127:0] cx, cy, cz, sx, sy, sz);
    for (int k = 0; k < 8; k++) begin
      if (plane_passes(p, k[0] ? cx + sx : cx - sx, k[1] ? cy + sy : cy - sy,
                       k[2] ? cz + sz : cz - sz, 0))
        return 1'b1;
    end
    return 1'b0;
  endfunction

  // updates the plane copy; returns 1 and the visibility when a result is due
  function automatic bit cull_predict(cull_req_t r, output bit vis);
    logic signed [127:0] cx, cy, cz, sx, sy, sz;
    cx = signed'(r.cx); cy = signed'(r.cy); cz = signed'(r.cz);
    sx = signed'(r.sx); sy = signed'(r.sy); sz = signed'(r.sz);
    vis = 1'b1;
    if (r.cmd == CMD_WRITE) begin
      if (r.plane < N_PLANES) plane_coef[r.plane][r.comp] = r.coef;
      return 1'b0;
    end
    if (r.cmd > CMD_CUBE) return 1'b0;
    for (int p = 0; p < N_PLANES && vis; p++) begin
      case (r.cmd)
        CMD_POINT:  vis = plane_passes(p, cx, cy, cz, 0);
        CMD_SPHERE: vis = plane_passes(p, cx, cy, cz, sx);
        CMD_BOX:    vis = box_passes(p, cx, cy, cz, sx, sy, sz);
        default:    vis = box_passes(p, cx, cy, cz, sx, sx, sx);
      endcase
    end
    return 1'b1;
  endfunction

  function automatic cull_req_t mk(int cmd, int plane, int comp,
                                   logic [31:0] coef, logic [31:0] cx, cy, cz, sx, sy, sz,
                                   int vis);
    cull_req_t r;
    r.cmd = 3'(cmd); r.plane = 3'(plane); r.comp = 2'(comp); r.coef = coef;
    r.cx = cx; r.cy = cy; r.cz = cz; r.sx = sx; r.sy = sy; r.sz = sz;
    r.vis = vis;
    return r;
  endfunction

  function automatic logic [31:0] rnd_near(int unsigned span);
    return $urandom_range(0, 2 * span) - span;
  endfunction

  task automatic send(cull_req_t r);
    bit vis;
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 20);
    end
    s_axis_tdata  <= {r.sz, r.sy, r.sx, r.cz, r.cy, r.cx, r.coef, r.comp, r.plane, r.cmd};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    burst_left--;
    if (cull_predict(r, vis)) visible_q.push_back(r.vis == NO_CHECK ? vis : r.vis[0]);
  endtask

  task automatic load_frustum();
    // axis-aligned slab per plane pair with some tilt
    for (int p = 0; p < N_PLANES; p++) begin
      for (int c = 0; c < 3; c++)
        send(mk(CMD_WRITE, p, c, (c == p / 2) ? ((p % 2) ? -32'sh10000 : 32'sh10000)
                                              : rnd_near(32'h2000),
                0, 0, 0, 0, 0, 0, NO_CHECK));
      send(mk(CMD_WRITE, p, 3, $urandom_range(0, 32'h30000), 0, 0, 0, 0, 0, 0, NO_CHECK));
    end
  endtask

  // result side: checking, stall pattern, watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles <= 0;
      else if (idle_cycles + 1 >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end else
        idle_cycles <= idle_cycles + 1;
      if (m_axis_tvalid && m_axis_tready) begin
        if (visible_q.size() == 0) begin
          $display("%0t: unexpected transfer, visible=%0d", $time, m_axis_tdata[0]);
          errors++;
        end else begin
          if (m_axis_tdata[0] !== visible_q[0] || m_axis_tdata[7:1] !== 7'd0) begin
            $display("%0t: visible expected %0d, actual tdata %h", $time,
                     visible_q[0], m_axis_tdata);
            errors++;
          end
          void'(visible_q.pop_front());
        end
      end
      ready_cycle <= ready_cycle + 1;
      if (ready_cycle % 64 == 0) ready_mode <= $urandom_range(0, 2);
      case (ready_mode)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= 1'($urandom_range(0, 1));
        default: m_axis_tready <= (ready_cycle % 4 == 0);
      endcase
    end
  end

  initial begin
    int r;
    for (int p = 0; p < N_PLANES; p++)
      for (int c = 0; c < 4; c++) plane_coef[p][c] = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // cleared store passes everything
    dir_rows.push_back(mk(CMD_POINT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1));
    dir_rows.push_back(mk(CMD_CUBE, 7, 3, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'h80000000,
                          32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 1));
    dir_rows.push_back(mk(5, 0, 0, 0, 0, 0, 0, 0, 0, 0, NO_CHECK));
    dir_rows.push_back(mk(6, 0, 0, 0, 0, 0, 0, 0, 0, 0, NO_CHECK));
    dir_rows.push_back(mk(7, 0, 0, 0, 0, 0, 0, 0, 0, 0, NO_CHECK));
    // out-of-range plane writes are dropped
    dir_rows.push_back(mk(CMD_WRITE, 6, 3, 32'h80000000, 0, 0, 0, 0, 0, 0, NO_CHECK));
    dir_rows.push_back(mk(CMD_WRITE, 7, 0, 32'h80000000, 0, 0, 0, 0, 0, 0, NO_CHECK));
    dir_rows.push_back(mk(CMD_POINT, 0, 0, 0, 32'hFFFFFFFF, 0, 0, 0, 0, 0, 1));
    // left plane x >= 0
    dir_rows.push_back(mk(CMD_WRITE, 0, 0, 32'h10000, 0, 0, 0, 0, 0, 0, NO_CHECK));
    dir_rows.push_back(mk(CMD_POINT, 0, 0, 0, 32'hFFFFFFFF, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk(CMD_POINT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1));
    dir_rows.push_back(mk(CMD_SPHERE, 0, 0, 0, -32'sd5, 0, 0, 5, 0, 0, 1));
    dir_rows.push_back(mk(CMD_SPHERE, 0, 0, 0, -32'sd5, 0, 0, 4, 0, 0, 0));
    dir_rows.push_back(mk(CMD_SPHERE, 0, 0, 0, 0, 0, 0, 32'hFFFFFFFF, 0, 0, 0));
    dir_rows.push_back(mk(CMD_BOX, 0, 0, 0, -32'sd10, 0, 0, 10, 3, 3, 1));
    dir_rows.push_back(mk(CMD_BOX, 0, 0, 0, -32'sd10, 0, 0, 9, 3, 3, 0));
    dir_rows.push_back(mk(CMD_BOX, 0, 0, 0, -32'sd10, 0, 0, -32'sd10, -32'sd3, 3, 1));
    dir_rows.push_back(mk(CMD_CUBE, 0, 0, 0, -32'sd10, 0, 0, 10, 0, 0, 1));
    // far plane offset at its extremes
    dir_rows.push_back(mk(CMD_WRITE, 5, 3, 32'h80000000, 0, 0, 0, 0, 0, 0, NO_CHECK));
    dir_rows.push_back(mk(CMD_POINT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk(CMD_WRITE, 5, 3, 32'h7FFFFFFF, 0, 0, 0, 0, 0, 0, NO_CHECK));
    dir_rows.push_back(mk(CMD_POINT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1));
    dir_rows.push_back(mk(CMD_WRITE, 2, 1, 32'h80000000, 0, 0, 0, 0, 0, 0, NO_CHECK));
    dir_rows.push_back(mk(CMD_WRITE, 3, 2, 32'h7FFFFFFF, 0, 0, 0, 0, 0, 0, NO_CHECK));
    dir_rows.push_back(mk(CMD_CUBE, 0, 0, 0, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                          32'h80000000, 0, 0, NO_CHECK));
    foreach (dir_rows[i]) send(dir_rows[i]);

    load_frustum();
    for (int n = 0; n < N_RANDOM; n++) begin
      r = $urandom_range(0, 99);
      if (r < 3)
        load_frustum();
      else if (r < 18)
        send(mk(CMD_WRITE, $urandom_range(0, 7), $urandom_range(0, 3),
                ($urandom_range(0, 1) ? $urandom : rnd_near(32'h20000)),
                $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, NO_CHECK));
      else if (r < 21)
        send(mk($urandom_range(5, 7), $urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom, $urandom, NO_CHECK));
      else if (r < 36)
        send(mk($urandom_range(CMD_POINT, CMD_CUBE), $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, NO_CHECK));
      else
        send(mk($urandom_range(CMD_POINT, CMD_CUBE), $urandom, $urandom, $urandom,
                rnd_near(32'h40000), rnd_near(32'h40000), rnd_near(32'h40000),
                $urandom_range(0, 9) == 0 ? rnd_near(32'h8000) : $urandom_range(0, 32'h20000),
                $urandom_range(0, 32'h20000), $urandom_range(0, 32'h20000), NO_CHECK));
    end
    s_axis_tvalid <= 1'b0;

    while (visible_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0 && visible_q.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
